[design/swdp_pkg.sv]
package swdp_pkg;

    localparam int MAX_DIM_DEFAULT = 1024;

    localparam int OP_W   = 3;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int RES_W  = 64;
    localparam int KIND_W = 2;
    localparam int LEN_W  = 11;
    localparam int W_W    = 32;

    localparam logic [LEN_W-1:0] LEN_RESET   = 11'd1024;
    localparam logic [31:0]      SCALE_ONE   = 32'h0100_0000;
    localparam logic [31:0]      SCALE_FLOOR = 32'd168;

    // Divider for the add path: (|update| << 24) + scale/2 over the scale.
    localparam int DIV_NUM_W = 56;
    localparam int DIV_DEN_W = 32;

    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_SCALE = 3'd2;
    localparam logic [OP_W-1:0] OP_DOT   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;
    localparam logic [OP_W-1:0] OP_NORM  = 3'd5;

    localparam logic [KIND_W-1:0] KIND_DOT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NORM   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } item_t;

    typedef struct packed {
        logic signed [RES_W-1:0] result;
        logic [KIND_W-1:0]       result_kind;
    } result_t;

endpackage

[design/scaled_weight_store_dot_product_unit.sv]
// Scaled weight store with sparse dot product.
//
// Commands: an item (opcode, index, value, last) is taken at a rising edge
// with start high and busy low. Results (result, result_kind) appear on res
// with done high for exactly one cycle; the receiver cannot stall them, so the
// block never waits on its output side.
// Configuration: cfg_we writes cfg_wdata into active_length; write only while
// the block is idle.
//
// Steps per item; the weight RAM read and the shared multiplier are both
// registered, and every path but add and clear uses the multiplier:
//   dot element, not last: multiply, accumulate (busy low while accumulating)
//   dot element, last:     multiply, accumulate, take magnitude, rescale, emit
//   read weight:           multiply by the scale, round, emit
//   add update:            divide (one quotient bit a cycle), read, add, write
//   scale:                 multiply, set; when folded, fold each weight in use
//   squared norm:          square and sum each weight in use, rescale twice
//   clear:                 zero one RAM entry per cycle over all MAX_DIM
// Reset runs the same clearing pass over all MAX_DIM entries, with busy high,
// and sets the scale to one and active_length to 1024.
module scaled_weight_store_dot_product_unit #(
    parameter int MAX_DIM = swdp_pkg::MAX_DIM_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  swdp_pkg::item_t               item,
    output logic                          done,
    output swdp_pkg::result_t             res,
    input  logic                          cfg_we,
    input  logic [swdp_pkg::LEN_W-1:0]    cfg_wdata
);

    localparam int AW   = $clog2(MAX_DIM);
    localparam int XW   = (AW > swdp_pkg::IDX_W) ? AW : swdp_pkg::IDX_W;
    localparam int CLW  = $clog2(MAX_DIM + 1);
    localparam int LENW = (swdp_pkg::LEN_W > CLW) ? swdp_pkg::LEN_W : CLW;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_CLR      = 18'h00002,
        S_DOT_MUL  = 18'h00004,
        S_DOT_ACC  = 18'h00008,
        S_DOT_MAG  = 18'h00010,
        S_RD_MUL   = 18'h00020,
        S_RD_RND   = 18'h00040,
        S_ADD_DIV  = 18'h00080,
        S_ADD_WR   = 18'h00100,
        S_SCL_MUL  = 18'h00200,
        S_SCL_SET  = 18'h00400,
        S_WALK_RD  = 18'h00800,
        S_WALK_MUL = 18'h01000,
        S_WALK_WB  = 18'h02000,
        S_U_LO     = 18'h04000,
        S_U_HI     = 18'h08000,
        S_U_FIN    = 18'h10000,
        S_EMIT     = 18'h20000
    } state_t;

    function automatic logic [31:0] mag32(input logic [31:0] w);
        return w[31] ? (~w + 32'd1) : w;
    endfunction

    function automatic logic [63:0] from_mag64(input logic [63:0] m, input logic neg);
        logic [63:0] r;
        if (neg)
        begin
            r = m[63] ? S64_MIN : (~m + 64'd1);
        end
        else
        begin
            r = m[63] ? S64_MAX : m;
        end
        return r;
    endfunction

    // round(|w| * scale / 2^24), signed back and clamped to 32 bits
    function automatic logic [31:0] fold_sat(input logic [63:0] p, input logic neg);
        logic [63:0] t;
        logic [39:0] r;
        logic [31:0] w;
        t = p + 64'h0080_0000;
        r = t[63:24];
        if (neg)
        begin
            w = (r > 40'h00_8000_0000) ? 32'h8000_0000 : (~r[31:0] + 32'd1);
        end
        else
        begin
            w = (r > 40'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
        end
        return w;
    endfunction

    // Control state
    state_t                        state_reg, state_next;
    logic [AW-1:0]                 ctr_reg, ctr_next;
    logic [31:0]                   scale_reg, scale_next;
    logic [63:0]                   acc_reg, acc_next;
    logic                          done_reg, done_next;
    logic [swdp_pkg::LEN_W-1:0]    len_reg, len_next;

    // Datapath registers
    swdp_pkg::item_t               item_reg, item_next;
    logic                          valid_reg, valid_next;
    logic [swdp_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic                          pass_reg, pass_next;
    logic [63:0]                   sum_reg, sum_next;
    logic [63:0]                   m_reg, m_next;
    logic [63:0]                   plo_reg, plo_next;
    logic                          neg_reg, neg_next;
    logic [57:0]                   d_reg, d_next;
    swdp_pkg::result_t             res_reg, res_next;

    // RAM, multiplier and divider hookup
    logic                          mem_we, mem_re;
    logic [AW-1:0]                 mem_waddr, mem_raddr;
    logic [31:0]                   mem_wdata, mem_rdata;
    logic signed [32:0]            mul_a, mul_b;
    logic [63:0]                   mul_p;
    logic                          div_start, div_done;
    logic [swdp_pkg::DIV_NUM_W-1:0] div_dividend, div_quotient;
    logic [31:0]                   div_scale;

    logic                          accept;
    logic [LENW-1:0]               eff_len;
    logic                          in_valid;
    logic [XW-1:0]                 in_idx_ext, reg_idx_ext;
    logic [AW-1:0]                 in_addr, reg_addr;
    logic                          walk_last;

    logic [64:0]                   acc_sum;
    logic [63:0]                   acc_sat;
    logic [63:0]                   rd_rnd;
    logic [63:0]                   scl_rnd;
    logic [39:0]                   scl_p;
    logic [31:0]                   scl_new;
    logic [57:0]                   add_sum;
    logic [31:0]                   add_sat;
    logic [64:0]                   sq_sum;
    logic [63:0]                   sq_sat;
    logic [64:0]                   u_sum;
    logic [63:0]                   u_res;
    logic [57:0]                   q_ext;

    swdp_ram #(
        .WIDTH (swdp_pkg::W_W),
        .DEPTH (MAX_DIM)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    swdp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    swdp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_scale),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Busy drops in the accumulate cycle of a non-final dot element so that
    // the next element can be taken while this one accumulates.
    assign busy   = !((state_reg == S_IDLE) || ((state_reg == S_DOT_ACC) && !item_reg.last));
    assign accept = start && !busy;

    assign eff_len = (LENW'(len_reg) > LENW'(MAX_DIM)) ? LENW'(MAX_DIM) : LENW'(len_reg);
    assign in_valid    = LENW'(item.index) < eff_len;
    assign in_idx_ext  = XW'(item.index);
    assign in_addr     = in_idx_ext[AW-1:0];
    assign reg_idx_ext = XW'(item_reg.index);
    assign reg_addr    = reg_idx_ext[AW-1:0];
    assign walk_last   = (LENW'(ctr_reg) == (eff_len - LENW'(1)));

    // Dot accumulate, saturating
    assign acc_sum = {acc_reg[63], acc_reg} + (valid_reg ? {mul_p[63], mul_p} : 65'd0);
    assign acc_sat = (acc_sum[64] != acc_sum[63]) ? (acc_sum[64] ? S64_MIN : S64_MAX)
                                                  : acc_sum[63:0];

    // Read weight: round(|w| * scale / 2^8)
    assign rd_rnd = mul_p + 64'h80;

    // New scale: round(scale * factor / 2^24), clamped to 32 bits
    assign scl_rnd = mul_p + 64'h0080_0000;
    assign scl_p   = scl_rnd[63:24];
    assign scl_new = (|scl_p[39:32]) ? 32'hFFFF_FFFF : scl_p[31:0];

    // Add update: divide by the scale, or by one if it were ever zero
    assign div_scale    = (scale_reg == 32'd0) ? swdp_pkg::SCALE_ONE : scale_reg;
    assign div_dividend = {mag32(item.value), 24'd0} + swdp_pkg::DIV_NUM_W'(div_scale >> 1);
    assign q_ext        = {2'b00, div_quotient};
    assign add_sum      = {{26{mem_rdata[31]}}, mem_rdata} + d_reg;
    assign add_sat      = (add_sum[57:31] == {27{add_sum[57]}}) ? add_sum[31:0] :
                          (add_sum[57] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    // Norm sum of squares, saturating unsigned
    assign sq_sum = {1'b0, sum_reg} + {1'b0, mul_p};
    assign sq_sat = sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_sum[63:0];

    // Combine the two partial products of m * scale / 2^24
    assign u_sum = {1'b0, mul_p[55:0], 8'd0} + {25'd0, plo_reg[63:24]};
    assign u_res = ((|mul_p[63:56]) || u_sum[64]) ? 64'hFFFF_FFFF_FFFF_FFFF : u_sum[63:0];

    always_comb
    begin
        state_next = state_reg;
        ctr_next   = ctr_reg;
        scale_next = scale_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        len_next   = cfg_we ? cfg_wdata : len_reg;
        item_next  = item_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        pass_next  = pass_reg;
        sum_next   = sum_reg;
        m_next     = m_reg;
        plo_next   = plo_reg;
        neg_next   = neg_reg;
        d_next     = d_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = ctr_reg;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = ctr_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_CLR:
            begin
                // zero one entry per cycle over the whole RAM
                mem_we    = 1'b1;
                mem_wdata = '0;
                ctr_next  = ctr_reg + AW'(1);
                if (ctr_reg == AW'(MAX_DIM - 1))
                begin
                    ctr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_DOT_MUL:
            begin
                mul_a      = $signed({item_reg.value[31], item_reg.value});
                mul_b      = $signed({mem_rdata[31], mem_rdata});
                state_next = S_DOT_ACC;
            end
            S_DOT_ACC:
            begin
                acc_next   = acc_sat;
                state_next = item_reg.last ? S_DOT_MAG : S_IDLE;
            end
            S_DOT_MAG:
            begin
                m_next     = acc_reg[63] ? (~acc_reg + 64'd1) : acc_reg;
                neg_next   = acc_reg[63];
                acc_next   = '0;
                pass_next  = 1'b1;
                state_next = S_U_LO;
            end
            S_RD_MUL:
            begin
                mul_a      = $signed({1'b0, (valid_reg ? mag32(mem_rdata) : 32'd0)});
                mul_b      = $signed({1'b0, scale_reg});
                neg_next   = valid_reg && mem_rdata[31];
                state_next = S_RD_RND;
            end
            S_RD_RND:
            begin
                m_next     = {8'd0, rd_rnd[63:8]};
                state_next = S_EMIT;
            end
            S_ADD_DIV:
            begin
                if (div_done)
                begin
                    d_next     = item_reg.value[31] ? (~q_ext + 58'd1) : q_ext;
                    mem_re     = 1'b1;
                    mem_raddr  = reg_addr;
                    state_next = S_ADD_WR;
                end
            end
            S_ADD_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = reg_addr;
                mem_wdata  = add_sat;
                state_next = S_IDLE;
            end
            S_SCL_MUL:
            begin
                // a negative factor counts as zero
                mul_a      = $signed({1'b0, (item_reg.value[31] ? 32'd0 : item_reg.value)});
                mul_b      = $signed({1'b0, scale_reg});
                state_next = S_SCL_SET;
            end
            S_SCL_SET:
            begin
                scale_next = scl_new;
                state_next = S_IDLE;
                if (scl_new < swdp_pkg::SCALE_FLOOR)
                begin
                    if (eff_len == '0)
                    begin
                        scale_next = swdp_pkg::SCALE_ONE;
                    end
                    else
                    begin
                        ctr_next   = '0;
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ctr_reg;
                state_next = S_WALK_MUL;
            end
            S_WALK_MUL:
            begin
                mul_a      = $signed({1'b0, mag32(mem_rdata)});
                mul_b      = (item_reg.opcode == swdp_pkg::OP_SCALE) ?
                             $signed({1'b0, scale_reg}) : $signed({1'b0, mag32(mem_rdata)});
                neg_next   = mem_rdata[31];
                state_next = S_WALK_WB;
            end
            S_WALK_WB:
            begin
                if (item_reg.opcode == swdp_pkg::OP_SCALE)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ctr_reg;
                    mem_wdata = fold_sat(mul_p, neg_reg);
                end
                else
                begin
                    sum_next = sq_sat;
                end
                if (walk_last)
                begin
                    ctr_next = '0;
                    if (item_reg.opcode == swdp_pkg::OP_SCALE)
                    begin
                        scale_next = swdp_pkg::SCALE_ONE;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        m_next     = sq_sat;
                        neg_next   = 1'b0;
                        pass_next  = 1'b0;
                        state_next = S_U_LO;
                    end
                end
                else
                begin
                    ctr_next   = ctr_reg + AW'(1);
                    state_next = S_WALK_RD;
                end
            end
            S_U_LO:
            begin
                mul_a      = $signed({1'b0, m_reg[31:0]});
                mul_b      = $signed({1'b0, scale_reg});
                state_next = S_U_HI;
            end
            S_U_HI:
            begin
                mul_a      = $signed({1'b0, m_reg[63:32]});
                mul_b      = $signed({1'b0, scale_reg});
                plo_next   = mul_p + 64'h0080_0000;
                state_next = S_U_FIN;
            end
            S_U_FIN:
            begin
                m_next = u_res;
                if (pass_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    // norm takes the scale twice
                    pass_next  = 1'b1;
                    state_next = S_U_LO;
                end
            end
            S_EMIT:
            begin
                res_next.result      = from_mag64(m_reg, neg_reg);
                res_next.result_kind = kind_reg;
                done_next            = 1'b1;
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Dispatch a new item; from a dot accumulate cycle only clear touches
        // the accumulator, and it wins.
        if (accept)
        begin
            item_next  = item;
            valid_next = in_valid;
            unique case (item.opcode)
                swdp_pkg::OP_CLEAR:
                begin
                    scale_next = swdp_pkg::SCALE_ONE;
                    acc_next   = '0;
                    ctr_next   = '0;
                    state_next = S_CLR;
                end
                swdp_pkg::OP_ADD:
                begin
                    if (in_valid)
                    begin
                        div_start  = 1'b1;
                        state_next = S_ADD_DIV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                swdp_pkg::OP_SCALE:
                begin
                    state_next = S_SCL_MUL;
                end
                swdp_pkg::OP_DOT:
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = in_addr;
                    kind_next  = swdp_pkg::KIND_DOT;
                    state_next = S_DOT_MUL;
                end
                swdp_pkg::OP_READ:
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = in_addr;
                    kind_next  = swdp_pkg::KIND_WEIGHT;
                    state_next = S_RD_MUL;
                end
                swdp_pkg::OP_NORM:
                begin
                    kind_next = swdp_pkg::KIND_NORM;
                    if (eff_len == '0)
                    begin
                        m_next     = '0;
                        neg_next   = 1'b0;
                        pass_next  = 1'b0;
                        state_next = S_U_LO;
                    end
                    else
                    begin
                        sum_next   = '0;
                        ctr_next   = '0;
                        state_next = S_WALK_RD;
                    end
                end
                default:
                begin
                    // unused opcodes: drop
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ctr_reg   <= '0;
            scale_reg <= swdp_pkg::SCALE_ONE;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
            len_reg   <= swdp_pkg::LEN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            scale_reg <= scale_next;
            acc_reg   <= acc_next;
            done_reg  <= done_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        valid_reg <= valid_next;
        kind_reg  <= kind_next;
        pass_reg  <= pass_next;
        sum_reg   <= sum_next;
        m_reg     <= m_next;
        plo_reg   <= plo_next;
        neg_reg   <= neg_next;
        d_reg     <= d_next;
        res_reg   <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

[design/swdp_ram.sv]
module swdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/swdp_mul.sv]
module swdp_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic [63:0]        p
);

    logic signed [65:0] prod;
    logic [63:0]        p_reg;

    // Operands are sign- or zero-extended by the caller; the low 64 bits hold
    // both the signed 32x32 and the unsigned 32x32 product.
    assign prod = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= prod[63:0];
    end

    assign p = p_reg;

endmodule

[design/swdp_div.sv]
module swdp_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [swdp_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [swdp_pkg::DIV_DEN_W-1:0] divisor,
    output logic                           done,
    output logic [swdp_pkg::DIV_NUM_W-1:0] quotient
);

    localparam int N     = swdp_pkg::DIV_NUM_W;
    localparam int D     = swdp_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(N);

    logic             running_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [N-1:0]     quo_reg;
    logic [D-1:0]     rem_reg;
    logic [D-1:0]     den_reg;

    logic [D:0]       rem_sh;
    logic [D:0]       diff;
    logic             ge;

    // Restoring division, one quotient bit per cycle.
    assign rem_sh = {rem_reg, quo_reg[N-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                running_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (running_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(N - 1))
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (running_reg)
        begin
            quo_reg <= {quo_reg[N-2:0], ge};
            rem_reg <= ge ? diff[D-1:0] : rem_sh[D-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/swdp_checker.sv]
module swdp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input swdp_pkg::item_t   item,
    input logic              done,
    input swdp_pkg::result_t res
);

    // a result always follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result without preceding work");

    // no two results back to back
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("results in consecutive cycles");

    // a read weight item is answered with a weight result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.opcode == swdp_pkg::OP_READ))
        |-> ##4 (done && (res.result_kind == swdp_pkg::KIND_WEIGHT)))
        else $error("read weight result missing or late");

    // a non-final dot element keeps busy high while multiplying, then frees the command port
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.opcode == swdp_pkg::OP_DOT) && !item.last)
        |=> busy ##1 !busy)
        else $error("dot element did not stream");

endmodule

bind scaled_weight_store_dot_product_unit swdp_checker u_swdp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .res   (res)
);

[verif/tb_scaled_weight_store_dot_product_unit.sv]
`timescale 1ns / 100ps

module tb_scaled_weight_store_dot_product_unit;
    import swdp_pkg::*;

    localparam int DIM          = MAX_DIM_DEFAULT;
    localparam int CLK_HALF     = 6;
    // Longest silent stretch of a correct run is a norm or a fold over 1024
    // weights plus a sender gap; allow several times that.
    localparam int IDLE_LIMIT   = 20000;
    // Room for a last dot result to follow its item, with a little margin.
    localparam int SETTLE       = 16;
    localparam int RAND_PHASES  = 14;
    localparam int PHASE_ITEMS  = 100;
    localparam int MAX_REPORTS  = 100;

    // Opcodes the block must ignore.
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam logic signed [63:0] Q32_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q32_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] W_HI_64  = 64'sd2147483647;
    localparam logic signed [63:0] W_LO_64  = -64'sd2147483648;
    localparam logic signed [31:0] W_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] W_MIN    = 32'sh8000_0000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    item_t            item;
    logic             done;
    result_t          res;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    scaled_weight_store_dot_product_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the weight store: Q16.16 weights, Q8.24 scale,
    // Q32.32 dot accumulator and the active length register.
    logic signed [31:0] w_mem [DIM];
    logic [31:0]        scale_q;
    logic signed [63:0] dot_acc;
    logic [LEN_W-1:0]   len_q;

    // Q32.32 results owed by the block, oldest first.
    result_t q32_due [$];

    int idle_cycles;
    int mismatches;
    int burst_left;

    // One directed step: either an item or a write of the length register.
    typedef struct {
        bit               is_cfg;
        logic [LEN_W-1:0] len;
        item_t            cmd;
        bit               fixed;
        result_t          want;
    } step_t;

    step_t plan [$];

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    //------------------------------------------------------------------
    // Predictor arithmetic
    //------------------------------------------------------------------

    function automatic int unsigned live_len();
        return (len_q > DIM) ? DIM : int'(len_q);
    endfunction

    function automatic logic [63:0] mag64(logic signed [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // round(m * s / 2^24), pinned at 2^64-1
    function automatic logic [63:0] mul_q24(logic [63:0] m, logic [31:0] s);
        logic [127:0] p;
        p = (128'(m) * 128'(s) + 128'h80_0000) >> 24;
        return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    // Apply a sign to a magnitude, saturating to the signed 64-bit range.
    function automatic logic signed [63:0] signed_sat(logic [63:0] m, bit neg);
        if (neg)
            return (m >= 64'h8000_0000_0000_0000) ? Q32_MIN : -$signed(m);
        return m[63] ? Q32_MAX : $signed(m);
    endfunction

    function automatic logic signed [31:0] sat_w32(logic signed [63:0] v);
        if (v > W_HI_64)
            return W_MAX;
        if (v < W_LO_64)
            return W_MIN;
        return v[31:0];
    endfunction

    function automatic void wipe_store();
        foreach (w_mem[i])
            w_mem[i] = '0;
        scale_q = SCALE_ONE;
        dot_acc = '0;
    endfunction

    // Advance the shadow store by one item; return 1 with the result when
    // the item produces one.
    function automatic bit apply_weight_op(item_t it, output result_t r);
        int unsigned        n;
        int unsigned        i;
        bit                 in_range;
        logic [63:0]        m;
        logic [63:0]        q;
        logic [63:0]        sum;
        logic [63:0]        sq;
        logic [64:0]        wide;
        logic [31:0]        s;
        logic signed [63:0] val;
        logic signed [63:0] w;
        logic signed [63:0] prod;
        logic signed [63:0] acc;
        n        = live_len();
        in_range = it.index < n;
        val      = $signed(it.value);
        r        = '0;
        case (it.opcode)
            OP_CLEAR:
                wipe_store();
            OP_ADD:
                if (in_range)
                begin
                    // divide the update by the scale, rounding the magnitude
                    s = (scale_q != 0) ? scale_q : SCALE_ONE;
                    q = ((mag64(val) << 24) + (s >> 1)) / s;
                    w = w_mem[it.index];
                    w_mem[it.index] = sat_w32(val[63] ? w - $signed(q) : w + $signed(q));
                end
            OP_SCALE:
            begin
                m       = val[63] ? 64'd0 : val;
                m       = (m * scale_q + 64'h80_0000) >> 24;
                scale_q = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
                if (scale_q < SCALE_FLOOR)
                begin
                    // fold the scale into every weight in use
                    for (i = 0; i < n; i++)
                    begin
                        w        = w_mem[i];
                        w_mem[i] = sat_w32(signed_sat(mul_q24(mag64(w), scale_q), w[63]));
                    end
                    scale_q = SCALE_ONE;
                end
            end
            OP_DOT:
            begin
                if (in_range)
                begin
                    w    = w_mem[it.index];
                    prod = val * w;
                    acc  = dot_acc + prod;
                    if (dot_acc[63] == prod[63] && acc[63] != prod[63])
                        acc = prod[63] ? Q32_MIN : Q32_MAX;
                    dot_acc = acc;
                end
                if (it.last)
                begin
                    r.result      = signed_sat(mul_q24(mag64(dot_acc), scale_q), dot_acc[63]);
                    r.result_kind = KIND_DOT;
                    dot_acc       = '0;
                    return 1'b1;
                end
            end
            OP_READ:
            begin
                r.result_kind = KIND_WEIGHT;
                if (in_range)
                begin
                    w        = w_mem[it.index];
                    m        = (mag64(w) * scale_q + 64'h80) >> 8;
                    r.result = signed_sat(m, w[63]);
                end
                return 1'b1;
            end
            OP_NORM:
            begin
                sum = '0;
                for (i = 0; i < n; i++)
                begin
                    w    = w_mem[i];
                    m    = mag64(w);
                    sq   = m * m;
                    wide = {1'b0, sum} + {1'b0, sq};
                    sum  = wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
                end
                r.result      = signed_sat(mul_q24(mul_q24(sum, scale_q), scale_q), 1'b0);
                r.result_kind = KIND_NORM;
                return 1'b1;
            end
            default:
                ;
        endcase
        return 1'b0;
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    function automatic item_t pack_cmd(logic [OP_W-1:0] op, int idx, logic [31:0] val, bit l);
        item_t it;
        it.opcode = op;
        it.index  = IDX_W'(idx);
        it.value  = val;
        it.last   = l;
        return it;
    endfunction

    function automatic step_t cmd(logic [OP_W-1:0] op, int idx, logic [31:0] val, bit l);
        step_t st;
        st.is_cfg = 1'b0;
        st.len    = '0;
        st.cmd    = pack_cmd(op, idx, val, l);
        st.fixed  = 1'b0;
        st.want   = '0;
        return st;
    endfunction

    function automatic step_t cmd_want(logic [OP_W-1:0] op, int idx, logic [31:0] val, bit l,
                                       logic [63:0] rv, logic [KIND_W-1:0] kind);
        step_t st;
        st                  = cmd(op, idx, val, l);
        st.fixed            = 1'b1;
        st.want.result      = rv;
        st.want.result_kind = kind;
        return st;
    endfunction

    function automatic step_t len_step(logic [LEN_W-1:0] n);
        step_t st;
        st        = cmd(OP_CLEAR, 0, 0, 1'b0);
        st.is_cfg = 1'b1;
        st.len    = n;
        return st;
    endfunction

    // Small values near +/-2.0 most often, plus full-range values and extremes.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            3, 4, 5: return $urandom();
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // Mostly positions in use; now and then anywhere in the store.
    function automatic int pick_index();
        int unsigned n;
        n = live_len();
        if (n == 0 || $urandom_range(0, 6) == 0)
            return $urandom_range(0, DIM - 1);
        return $urandom_range(0, n - 1);
    endfunction

    // Scale factors in Q8.24: mostly near 1.0 so the scale drifts slowly.
    function automatic logic [31:0] pick_factor();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 200);
            1:       return 32'h8000_0000 | $urandom();
            2:       return $urandom();
            default: return $urandom_range(32'h00C0_0000, 32'h0140_0000);
        endcase
    endfunction

    // Present one item and hold it until taken. The sender runs in bursts:
    // at the start of each burst, drop start for a random gap (or none).
    // busy only moves at rising edges, so its value here decides acceptance.
    task automatic issue_cmd(item_t it, bit use_fixed = 1'b0, result_t fixed_res = '0);
        int      gap;
        bit      has_r;
        result_t r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        while (busy)
            @(negedge clk);
        // taken at the coming rising edge
        has_r = apply_weight_op(it, r);
        if (has_r)
            q32_due.push_back(use_fixed ? fixed_res : r);
    endtask

    // Write the length register once the block has gone quiet.
    task automatic set_length(logic [LEN_W-1:0] n);
        @(negedge clk);
        start <= 1'b0;
        while (q32_due.size() != 0)
            @(negedge clk);
        // items with no result may still be in flight
        repeat (SETTLE) @(negedge clk);
        while (busy)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(negedge clk);
        cfg_we <= 1'b0;
        len_q = n;
    endtask

    //------------------------------------------------------------------
    // Result checking and watchdog
    //------------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no item or result for %0d cycles", $time, IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
            else if (done)
            begin
                if (q32_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result: expected none, got %h kind %0d",
                                 $time, res.result, res.result_kind);
                end
                else
                begin
                    want = q32_due.pop_front();
                    if (res.result !== want.result)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: result: expected %h, got %h",
                                     $time, want.result, res.result);
                    end
                    if (res.result_kind !== want.result_kind)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: result_kind: expected %0d, got %0d",
                                     $time, want.result_kind, res.result_kind);
                    end
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------

    initial
    begin : main
        int               p;
        int               j;
        int               k;
        int               sent;
        int               pick;
        logic [LEN_W-1:0] n_len;

        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        idle_cycles = 0;
        mismatches  = 0;
        burst_left  = 0;
        wipe_store();
        len_q = LEN_RESET;

        // Directed steps. Results typed in here can be read straight off
        // the arithmetic; the rest come from the predictor.
        // After reset every weight and the norm read back as zero.
        plan.push_back(cmd_want(OP_READ, 0, 0, 1'b0, 64'd0, KIND_WEIGHT));
        plan.push_back(cmd_want(OP_NORM, 0, 0, 1'b0, 64'd0, KIND_NORM));
        // 1.0 added at position 0 reads back as 1.0 in Q32.32.
        plan.push_back(cmd(OP_ADD, 0, 32'h0001_0000, 1'b0));
        plan.push_back(cmd_want(OP_READ, 0, 0, 1'b0, 64'h0000_0001_0000_0000, KIND_WEIGHT));
        // Drive the top weight into positive saturation, weight 1 negative.
        plan.push_back(cmd(OP_ADD, 1023, 32'h7FFF_FFFF, 1'b0));
        plan.push_back(cmd(OP_ADD, 1023, 32'h7FFF_FFFF, 1'b1));
        plan.push_back(cmd_want(OP_READ, 1023, 0, 1'b0, 64'h0000_7FFF_FFFF_0000, KIND_WEIGHT));
        plan.push_back(cmd(OP_ADD, 1, 32'h8000_0000, 1'b0));
        plan.push_back(cmd(OP_ADD, 1, 32'h8000_0000, 1'b1));
        // Saturate the accumulator; a spare opcode and a read between the
        // elements must leave it alone.
        plan.push_back(cmd(OP_DOT, 1, 32'h8000_0000, 1'b0));
        plan.push_back(cmd(OP_DOT, 1, 32'h8000_0000, 1'b0));
        plan.push_back(cmd(OP_SPARE6, 1, 32'h8000_0000, 1'b1));
        plan.push_back(cmd_want(OP_READ, 1, 0, 1'b0, 64'hFFFF_8000_0000_0000, KIND_WEIGHT));
        plan.push_back(cmd_want(OP_DOT, 1, 32'h8000_0000, 1'b1, Q32_MAX, KIND_DOT));
        plan.push_back(cmd(OP_SPARE7, 1023, 32'hFFFF_FFFF, 1'b1));
        // Halve the scale, then a one-element dot against the top weight.
        plan.push_back(cmd(OP_SCALE, 0, 32'h0080_0000, 1'b0));
        plan.push_back(cmd(OP_DOT, 1023, 32'h7FFF_FFFF, 1'b1));
        // A negative factor counts as zero and folds the scale away.
        plan.push_back(cmd(OP_SCALE, 0, 32'h8000_0000, 1'b0));
        plan.push_back(cmd(OP_NORM, 0, 0, 1'b0));
        // Push the scale to its ceiling and take the norm there.
        plan.push_back(cmd(OP_ADD, 2, 32'h7FFF_FFFF, 1'b0));
        plan.push_back(cmd(OP_SCALE, 0, 32'h7FFF_FFFF, 1'b0));
        plan.push_back(cmd(OP_SCALE, 0, 32'h7FFF_FFFF, 1'b0));
        plan.push_back(cmd(OP_NORM, 0, 0, 1'b0));
        // Short vector: positions past the end do nothing.
        plan.push_back(len_step(11'd4));
        plan.push_back(cmd_want(OP_READ, 4, 0, 1'b0, 64'd0, KIND_WEIGHT));
        plan.push_back(cmd(OP_ADD, 500, 32'h0001_0000, 1'b0));
        plan.push_back(cmd_want(OP_DOT, 900, 32'd5, 1'b1, 64'd0, KIND_DOT));
        // Zero length: nothing is in use.
        plan.push_back(len_step(11'd0));
        plan.push_back(cmd_want(OP_NORM, 0, 0, 1'b0, 64'd0, KIND_NORM));
        plan.push_back(len_step(11'd1024));
        plan.push_back(cmd(OP_CLEAR, 0, 0, 1'b0));
        plan.push_back(cmd_want(OP_READ, 1023, 0, 1'b0, 64'd0, KIND_WEIGHT));

        // Hold reset, then release it between edges.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                set_length(plan[i].len);
            else
                issue_cmd(plan[i].cmd, plan[i].fixed, plan[i].want);
        end

        // Random phases, each at its own vector length. The first few hit
        // the extremes of the register; later ones are mostly short vectors
        // so the walking ops stay cheap.
        for (p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:       n_len = 11'd1;
                1:       n_len = 11'd0;
                2:       n_len = 11'd2047;
                3:       n_len = 11'd1024;
                4:       n_len = 11'd2;
                default: n_len = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(65, 2047))
                                                           : LEN_W'($urandom_range(1, 64));
            endcase
            set_length(n_len);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    // well-formed dot product, now and then with another
                    // op slipped between its elements
                    k = $urandom_range(1, 8);
                    for (j = 0; j < k; j++)
                    begin
                        if (j > 0 && $urandom_range(0, 7) == 0)
                        begin
                            if ($urandom_range(0, 1))
                                issue_cmd(pack_cmd(OP_READ, pick_index(), pick_value(), 1'b1));
                            else
                                issue_cmd(pack_cmd(OP_SCALE, pick_index(), pick_factor(), 1'b1));
                            sent++;
                        end
                        issue_cmd(pack_cmd(OP_DOT, pick_index(), pick_value(), j == k - 1));
                    end
                    sent += k;
                end
                else
                begin
                    if (pick < 60)
                        issue_cmd(pack_cmd(OP_ADD, pick_index(), pick_value(),
                                           $urandom_range(0, 1)));
                    else if (pick < 75)
                        issue_cmd(pack_cmd(OP_READ, pick_index(), pick_value(),
                                           $urandom_range(0, 1)));
                    else if (pick < 85)
                        issue_cmd(pack_cmd(OP_SCALE, pick_index(), pick_factor(),
                                           $urandom_range(0, 1)));
                    else if (pick < 91)
                        issue_cmd(pack_cmd(OP_NORM, pick_index(), pick_value(),
                                           $urandom_range(0, 1)));
                    else if (pick < 93)
                        issue_cmd(pack_cmd(OP_CLEAR, pick_index(), pick_value(),
                                           $urandom_range(0, 1)));
                    else if (pick < 96)
                        issue_cmd(pack_cmd($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7,
                                           pick_index(), pick_value(), $urandom_range(0, 1)));
                    else
                        // noise: any opcode, any fields
                        issue_cmd(pack_cmd(OP_W'($urandom_range(0, 7)),
                                           $urandom_range(0, DIM - 1), $urandom(),
                                           $urandom_range(0, 1)));
                    sent++;
                end
            end
        end

        // Drain: drop start, wait for every owed result, then give a stray
        // result time to show up.
        @(negedge clk);
        start <= 1'b0;
        while (q32_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
design/swdp_pkg.sv
design/swdp_ram.sv
design/swdp_mul.sv
design/swdp_div.sv
design/scaled_weight_store_dot_product_unit.sv
design/swdp_checker.sv
verif/tb_scaled_weight_store_dot_product_unit.sv
